>>> sv/fcal_pkg.sv
// Shared types and constants for the fault confirm and alert limiter.
package fcal_pkg;

  localparam int unsigned LevelW = 17;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned EventW = 2;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  typedef logic [LevelW-1:0] level_t;
  typedef logic [TimeW-1:0]  time_t;
  typedef logic [EventW-1:0] event_t;

  // Event codes carried on the result channel.
  localparam event_t EvNone   = 2'd0;
  localparam event_t EvShort  = 2'd1;
  localparam event_t EvOutage = 2'd2;

  // Register indexes (word address divided by four).
  localparam logic [2:0] RegShortCurrThr  = 3'd0;
  localparam logic [2:0] RegShortVoltCol  = 3'd1;
  localparam logic [2:0] RegOutVoltThr    = 3'd2;
  localparam logic [2:0] RegOutCurrMax    = 3'd3;
  localparam logic [2:0] RegShortConfirm  = 3'd4;
  localparam logic [2:0] RegOutConfirm    = 3'd5;
  localparam logic [2:0] RegShortCooldown = 3'd6;
  localparam logic [2:0] RegOutCooldown   = 3'd7;

  // Reset values of the registers.
  localparam level_t RstShortCurrThr  = 17'd15000;
  localparam level_t RstShortVoltCol  = 17'd11000;
  localparam level_t RstOutVoltThr    = 17'd3000;
  localparam level_t RstOutCurrMax    = 17'd5000;
  localparam time_t  RstShortConfirm  = 32'd100;
  localparam time_t  RstOutConfirm    = 32'd3000;
  localparam time_t  RstShortCooldown = 32'd120000;
  localparam time_t  RstOutCooldown   = 32'd300000;

  // Timing settings of one fault channel.
  typedef struct packed {
    time_t confirm_ms;
    time_t cooldown_ms;
  } chan_cfg_t;

endpackage

>>> sv/fcal_chan.sv
// One fault channel: confirm timer and repeat limiter.
module fcal_chan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                cond,
  input  fcal_pkg::time_t     now,
  input  fcal_pkg::chan_cfg_t cfg,
  output logic                fire
);

  logic            pending_r, pending_nxt;
  logic            alerted_r, alerted_nxt;
  fcal_pkg::time_t start_r, start_nxt;
  fcal_pkg::time_t last_r, last_nxt;
  fcal_pkg::time_t since_start;
  fcal_pkg::time_t since_last;

  // A fresh condition starts timing at the present sample.
  assign start_nxt   = pending_r ? start_r : now;
  assign since_start = now - start_nxt;
  assign since_last  = now - last_r;

  assign fire = cond && (since_start >= cfg.confirm_ms) &&
                (!alerted_r || (since_last >= cfg.cooldown_ms));

  assign pending_nxt = cond;
  assign alerted_nxt = cond && (alerted_r || fire);
  assign last_nxt    = fire ? now : last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      alerted_r <= 1'b0;
      start_r   <= '0;
      last_r    <= '0;
    end else if (step) begin
      pending_r <= pending_nxt;
      alerted_r <= alerted_nxt;
      if (cond) begin
        start_r <= start_nxt;
      end
      last_r <= last_nxt;
    end
  end

endmodule

>>> sv/fault_confirm_and_alert_limiter_core.sv
// Fault confirm and alert limiter.
// Input channel: one word per calibrated sample (in_voltage_cv in 0.01 V,
// in_current_ma in mA, in_time_ms a wrapping millisecond timestamp), moved
// by in_valid and in_stall. Result channel: one word per sample with the
// event code and both raw fault conditions, moved by out_valid and out_stall.
// A sample is first captured in an input register; once the output register
// can load, the conditions and both channel timers are evaluated from that
// register and the result lands in the output register, which raises out_valid.
// One sample is accepted per cycle when the receiver keeps up; the limit is
// the single evaluation stage, which updates the channel state as it loads
// the output register.
// When out_stall is high the output word holds; the input register may still
// fill, and in_stall rises only once both registers are full.
// Thresholds (17 bits) and times (32 bits) are written over the APB port, one
// register per word address; reads return the stored value. Writes are meant
// for idle periods only.
// Reset (synchronous, active low) empties both registers, clears the pending
// and alerted marks and returns every setting to its default.
module fault_confirm_and_alert_limiter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fcal_pkg::level_t              in_voltage_cv,
  input  fcal_pkg::level_t              in_current_ma,
  input  fcal_pkg::time_t               in_time_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fcal_pkg::event_t              out_fault_event,
  output logic                          out_short_condition,
  output logic                          out_outage_condition,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcal_pkg::AddrW-1:0]    paddr,
  input  logic [fcal_pkg::DataW-1:0]    pwdata,
  output logic [fcal_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  // Settings registers.
  fcal_pkg::level_t short_curr_thr_r, short_volt_col_r;
  fcal_pkg::level_t out_volt_thr_r, out_curr_max_r;
  fcal_pkg::time_t  short_confirm_r, out_confirm_r;
  fcal_pkg::time_t  short_cooldown_r, out_cooldown_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_curr_thr_r <= fcal_pkg::RstShortCurrThr;
      short_volt_col_r <= fcal_pkg::RstShortVoltCol;
      out_volt_thr_r   <= fcal_pkg::RstOutVoltThr;
      out_curr_max_r   <= fcal_pkg::RstOutCurrMax;
      short_confirm_r  <= fcal_pkg::RstShortConfirm;
      out_confirm_r    <= fcal_pkg::RstOutConfirm;
      short_cooldown_r <= fcal_pkg::RstShortCooldown;
      out_cooldown_r   <= fcal_pkg::RstOutCooldown;
    end else if (cfg_wr) begin
      case (cfg_idx)
        fcal_pkg::RegShortCurrThr:  short_curr_thr_r <= pwdata[fcal_pkg::LevelW-1:0];
        fcal_pkg::RegShortVoltCol:  short_volt_col_r <= pwdata[fcal_pkg::LevelW-1:0];
        fcal_pkg::RegOutVoltThr:    out_volt_thr_r   <= pwdata[fcal_pkg::LevelW-1:0];
        fcal_pkg::RegOutCurrMax:    out_curr_max_r   <= pwdata[fcal_pkg::LevelW-1:0];
        fcal_pkg::RegShortConfirm:  short_confirm_r  <= pwdata;
        fcal_pkg::RegOutConfirm:    out_confirm_r    <= pwdata;
        fcal_pkg::RegShortCooldown: short_cooldown_r <= pwdata;
        fcal_pkg::RegOutCooldown:   out_cooldown_r   <= pwdata;
        default: ;
      endcase
    end
  end

  // Read data: narrow registers are zero-extended.
  always_comb begin
    case (cfg_idx)
      fcal_pkg::RegShortCurrThr:  prdata = {15'd0, short_curr_thr_r};
      fcal_pkg::RegShortVoltCol:  prdata = {15'd0, short_volt_col_r};
      fcal_pkg::RegOutVoltThr:    prdata = {15'd0, out_volt_thr_r};
      fcal_pkg::RegOutCurrMax:    prdata = {15'd0, out_curr_max_r};
      fcal_pkg::RegShortConfirm:  prdata = short_confirm_r;
      fcal_pkg::RegOutConfirm:    prdata = out_confirm_r;
      fcal_pkg::RegShortCooldown: prdata = short_cooldown_r;
      fcal_pkg::RegOutCooldown:   prdata = out_cooldown_r;
      default:                    prdata = '0;
    endcase
  end

  // Input register.
  logic             s1_valid_r;
  fcal_pkg::level_t s1_volt_r, s1_curr_r;
  fcal_pkg::time_t  s1_time_r;

  // Output register.
  logic             out_valid_r;
  fcal_pkg::event_t out_event_r;
  logic             out_short_r, out_outage_r;

  logic s1_move;   // the sample in the input register is evaluated this cycle
  logic in_take;   // a new word is accepted this cycle

  // The output register can load when it is empty or being drained.
  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_volt_r <= in_voltage_cv;
      s1_curr_r <= in_current_ma;
      s1_time_r <= in_time_ms;
    end
  end

  // Raw conditions. An outage never coincides with a short.
  logic sc_cond, po_cond;
  assign sc_cond = (s1_curr_r >= short_curr_thr_r) && (s1_volt_r <= short_volt_col_r);
  assign po_cond = (s1_volt_r <= out_volt_thr_r) && (s1_curr_r <= out_curr_max_r) &&
                   !sc_cond;

  fcal_pkg::chan_cfg_t short_cfg, outage_cfg;
  assign short_cfg  = '{confirm_ms: short_confirm_r, cooldown_ms: short_cooldown_r};
  assign outage_cfg = '{confirm_ms: out_confirm_r, cooldown_ms: out_cooldown_r};

  logic short_fire, outage_fire;

  fcal_chan u_short (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_move),
    .cond  (sc_cond),
    .now   (s1_time_r),
    .cfg   (short_cfg),
    .fire  (short_fire)
  );

  fcal_chan u_outage (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_move),
    .cond  (po_cond),
    .now   (s1_time_r),
    .cfg   (outage_cfg),
    .fire  (outage_fire)
  );

  fcal_pkg::event_t event_nxt;
  always_comb begin
    if (outage_fire) begin
      event_nxt = fcal_pkg::EvOutage;
    end else if (short_fire) begin
      event_nxt = fcal_pkg::EvShort;
    end else begin
      event_nxt = fcal_pkg::EvNone;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_event_r  <= event_nxt;
      out_short_r  <= sc_cond;
      out_outage_r <= po_cond;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_fault_event      = out_event_r;
  assign out_short_condition  = out_short_r;
  assign out_outage_condition = out_outage_r;

endmodule

>>> tb/sv/fault_confirm_and_alert_limiter_core_tb.sv
`timescale 1ns / 100ps

module fault_confirm_and_alert_limiter_core_tb;
  import fcal_pkg::*;

  // The run is stopped as failed if it is still going after this many cycles.
  // The slowest correct run (about 1660 words, part of them through an 85 %
  // stall) finishes well before that.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseWords  = 205;
  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned ZeroPhase   = 3;
  localparam int unsigned MaxPhase    = 7;
  localparam int unsigned DrainCycles = 10;
  localparam logic [31:0] LevelMax    = 32'h0001_FFFF;
  localparam logic [31:0] TimeMax     = 32'hFFFF_FFFF;

  // One result word as the block presents it.
  typedef struct packed {
    event_t fault_event;
    logic   short_cond;
    logic   outage_cond;
  } fault_word_t;

  // Confirm and repeat tracking of one fault kind.
  typedef struct packed {
    logic  pending;
    time_t start_ms;
    logic  alerted;
    time_t last_alert_ms;
  } fault_timer_t;

  // One row of the directed table: either a register write or a sample word,
  // the latter optionally with its result written out by hand.
  typedef struct packed {
    logic        is_reg_write;
    logic [2:0]  reg_idx;
    logic [31:0] reg_value;
    level_t      voltage;
    level_t      current;
    time_t       stamp;
    logic        typed;
    fault_word_t typed_word;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  level_t              in_voltage_cv;
  level_t              in_current_ma;
  time_t               in_time_ms;
  logic                out_valid;
  logic                out_stall;
  event_t              out_fault_event;
  logic                out_short_condition;
  logic                out_outage_condition;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;

  // Our own copy of the settings and of both fault timers.
  logic [31:0]         reg_file [0:7];
  fault_timer_t        short_timer;
  fault_timer_t        outage_timer;

  // Result words still owed by the block, oldest first.
  fault_word_t         fault_words_due [$];
  stim_row_t           directed_rows [$];

  int unsigned         sender_idle_pct;
  int unsigned         stall_pct;
  time_t               stamp_ms;
  int unsigned         cycle_count;
  int unsigned         errors;
  int unsigned         words_sent;
  int unsigned         settings_written;
  int unsigned         short_alerts;
  int unsigned         outage_alerts;

  fault_confirm_and_alert_limiter_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_voltage_cv        (in_voltage_cv),
    .in_current_ma        (in_current_ma),
    .in_time_ms           (in_time_ms),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_fault_event      (out_fault_event),
    .out_short_condition  (out_short_condition),
    .out_outage_condition (out_outage_condition),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  // Register values that the block takes on at reset.
  function automatic logic [31:0] default_setting(input logic [2:0] idx);
    case (idx)
      RegShortCurrThr:  return 32'(RstShortCurrThr);
      RegShortVoltCol:  return 32'(RstShortVoltCol);
      RegOutVoltThr:    return 32'(RstOutVoltThr);
      RegOutCurrMax:    return 32'(RstOutCurrMax);
      RegShortConfirm:  return RstShortConfirm;
      RegOutConfirm:    return RstOutConfirm;
      RegShortCooldown: return RstShortCooldown;
      default:          return RstOutCooldown;
    endcase
  endfunction

  // Settings for one phase. Phase 0 restores the defaults, one phase drives
  // everything to zero and another to the top of each field; the rest are
  // random, with the times mostly short so that alerts come often.
  function automatic logic [31:0] pick_setting(input logic [2:0] idx,
                                               input int unsigned phase);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (phase == 0) begin
      return default_setting(idx);
    end
    if (phase == ZeroPhase) begin
      return 32'd0;
    end
    if (phase == MaxPhase) begin
      return (idx <= RegOutCurrMax) ? LevelMax : TimeMax;
    end
    if (idx <= RegOutCurrMax) begin
      return $urandom_range(0, LevelMax);
    end
    if (roll < 60) begin
      return $urandom_range(0, 300);
    end else if (roll < 75) begin
      return 32'd0;
    end else if (roll < 92) begin
      return $urandom_range(300, 3000);
    end
    return $urandom;
  endfunction

  // Advance one fault timer by one sample. The confirm time counts from the
  // first sample of an unbroken run; repeats wait out the cooldown from the
  // last alert. All intervals are taken modulo 2^32, so a step backwards in
  // time reads as a very long interval.
  task automatic age_timer(inout fault_timer_t tmr, input logic cond,
                           input time_t now, input time_t confirm_ms,
                           input time_t cooldown_ms, output logic fired);
    time_t held_ms;
    time_t since_alert_ms;
    fired = 1'b0;
    if (!cond) begin
      tmr.pending = 1'b0;
      tmr.alerted = 1'b0;
    end else begin
      if (!tmr.pending) begin
        tmr.pending  = 1'b1;
        tmr.start_ms = now;
      end
      held_ms        = now - tmr.start_ms;
      since_alert_ms = now - tmr.last_alert_ms;
      if (held_ms >= confirm_ms && (!tmr.alerted || since_alert_ms >= cooldown_ms)) begin
        tmr.last_alert_ms = now;
        tmr.alerted       = 1'b1;
        fired             = 1'b1;
      end
    end
  endtask

  // Work out the result word for one accepted sample. A short circuit wins
  // over an outage, so the outage condition is masked by the short one.
  task automatic judge_sample(input level_t volt, input level_t curr, input time_t now,
                              output fault_word_t word);
    logic short_cond;
    logic outage_cond;
    logic short_fired;
    logic outage_fired;
    short_cond  = (curr >= reg_file[RegShortCurrThr][LevelW-1:0]) &&
                  (volt <= reg_file[RegShortVoltCol][LevelW-1:0]);
    outage_cond = (volt <= reg_file[RegOutVoltThr][LevelW-1:0]) &&
                  (curr <= reg_file[RegOutCurrMax][LevelW-1:0]) && !short_cond;
    age_timer(short_timer, short_cond, now, reg_file[RegShortConfirm],
              reg_file[RegShortCooldown], short_fired);
    age_timer(outage_timer, outage_cond, now, reg_file[RegOutConfirm],
              reg_file[RegOutCooldown], outage_fired);
    word.fault_event = outage_fired ? EvOutage : (short_fired ? EvShort : EvNone);
    word.short_cond  = short_cond;
    word.outage_cond = outage_cond;
  endtask

  function automatic void add_sample(input level_t volt, input level_t curr,
                                     input time_t stamp);
    stim_row_t row;
    row            = '0;
    row.voltage    = volt;
    row.current    = curr;
    row.stamp      = stamp;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_checked(input level_t volt, input level_t curr,
                                      input time_t stamp, input event_t ev,
                                      input logic short_cond, input logic outage_cond);
    stim_row_t row;
    row                        = '0;
    row.voltage                = volt;
    row.current                = curr;
    row.stamp                  = stamp;
    row.typed                  = 1'b1;
    row.typed_word.fault_event = ev;
    row.typed_word.short_cond  = short_cond;
    row.typed_word.outage_cond = outage_cond;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_setting(input logic [2:0] idx, input logic [31:0] value);
    stim_row_t row;
    row              = '0;
    row.is_reg_write = 1'b1;
    row.reg_idx      = idx;
    row.reg_value    = value;
    directed_rows.push_back(row);
  endfunction

  // Offer one sample word, after a random number of idle cycles, and hold it
  // until the block takes it. The expected result is queued at the edge of
  // acceptance, so the timers see samples in exactly the block's order.
  task automatic send_word(input level_t volt, input level_t curr, input time_t stamp,
                           input logic typed, input fault_word_t typed_word);
    fault_word_t due;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_voltage_cv <= volt;
    in_current_ma <= curr;
    in_time_ms    <= stamp;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    judge_sample(volt, curr, stamp, due);
    if (typed) begin
      due = typed_word;
    end
    fault_words_due.push_back(due);
    words_sent++;
  endtask

  // Stop sending and wait until every owed result word has come out. Each
  // sample yields exactly one word, so the block is idle once the queue is
  // empty.
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (fault_words_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write one register over the APB port and read it straight back. The
  // 17-bit thresholds keep only their low bits.
  task automatic write_setting(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] stored;
    stored  = (idx <= RegOutCurrMax) ? (value & LevelMax) : value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    reg_file[idx] = stored;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    if (prdata !== stored) begin
      $error("prdata (register %0d): expected %0h, got %0h", idx, stored, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    settings_written++;
  endtask

  // Random traffic for one phase. Most of it comes in runs that hold one
  // condition with a slowly advancing timestamp, so that confirm times and
  // cooldowns really expire; some runs are plain noise, and single samples
  // break runs now and then. A rare jump of the timestamp exercises the wrap.
  task automatic run_phase(input int unsigned n_words);
    int unsigned left;
    int unsigned run_len;
    int unsigned mode;
    int unsigned roll;
    level_t      volt;
    level_t      curr;
    left = n_words;
    while (left > 0) begin
      mode    = $urandom_range(0, 99);
      run_len = $urandom_range(1, 24);
      while (run_len > 0 && left > 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 90) begin
          stamp_ms += $urandom_range(0, 120);
        end else if (roll < 97) begin
          stamp_ms += $urandom_range(100, 2000);
        end else begin
          stamp_ms = $urandom;
        end
        volt = level_t'($urandom);
        curr = level_t'($urandom);
        if (mode < 40) begin
          volt = level_t'($urandom_range(0, reg_file[RegShortVoltCol]));
          curr = level_t'($urandom_range(reg_file[RegShortCurrThr], LevelMax));
          if ($urandom_range(0, 7) == 0) begin
            volt = reg_file[RegShortVoltCol][LevelW-1:0];
            curr = reg_file[RegShortCurrThr][LevelW-1:0];
          end
        end else if (mode < 75) begin
          volt = level_t'($urandom_range(0, reg_file[RegOutVoltThr]));
          curr = level_t'($urandom_range(0, reg_file[RegOutCurrMax]));
          if ($urandom_range(0, 7) == 0) begin
            volt = reg_file[RegOutVoltThr][LevelW-1:0];
            curr = reg_file[RegOutCurrMax][LevelW-1:0];
          end
        end
        if ($urandom_range(0, 19) == 0) begin
          volt = level_t'($urandom);
        end
        send_word(volt, curr, stamp_ms, 1'b0, '0);
        // Now and then the sender holds off until the block has fully drained.
        if ($urandom_range(0, 149) == 0) begin
          settle_block();
        end
        run_len--;
        left--;
      end
    end
  endtask

  // The receiver stalls at random, at the rate that the current phase sets.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Every word that leaves the block is compared with the oldest one owed.
  always @(posedge clk) begin : check_words
    fault_word_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (fault_words_due.size() == 0) begin
        $error("out word with no sample waiting: event %0d", out_fault_event);
        errors++;
      end else begin
        due = fault_words_due.pop_front();
        if (out_fault_event !== due.fault_event) begin
          $error("out_fault_event: expected %0d, got %0d", due.fault_event, out_fault_event);
          errors++;
        end
        if (out_short_condition !== due.short_cond) begin
          $error("out_short_condition: expected %0b, got %0b",
                 due.short_cond, out_short_condition);
          errors++;
        end
        if (out_outage_condition !== due.outage_cond) begin
          $error("out_outage_condition: expected %0b, got %0b",
                 due.outage_cond, out_outage_condition);
          errors++;
        end
        if (due.fault_event == EvShort) begin
          short_alerts++;
        end else if (due.fault_event == EvOutage) begin
          outage_alerts++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t   row;
    int unsigned pace;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_voltage_cv    = '0;
    in_current_ma    = '0;
    in_time_ms       = '0;
    out_stall        = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    sender_idle_pct  = 0;
    stall_pct        = 0;
    stamp_ms         = '0;
    cycle_count      = 0;
    errors           = 0;
    words_sent       = 0;
    settings_written = 0;
    short_alerts     = 0;
    outage_alerts    = 0;
    short_timer      = '0;
    outage_timer     = '0;
    for (int i = RegShortCurrThr; i <= RegOutCooldown; i++) begin
      reg_file[i] = default_setting(3'(i));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, starting from the reset settings. Zero voltage and
    // current is an outage that has only just begun; the top of both fields
    // is no fault at all.
    add_checked(17'd0, 17'd0, 32'd0, EvNone, 1'b0, 1'b1);
    add_checked(17'h1FFFF, 17'h1FFFF, 32'd10, EvNone, 1'b0, 1'b0);
    // A short circuit exactly at both thresholds, confirmed after 100 ms and
    // repeated only once the 120 s cooldown has run out.
    add_checked(17'd11000, 17'd15000, 32'd1000, EvNone, 1'b1, 1'b0);
    add_sample(17'd11000, 17'd15000, 32'd1099);
    add_checked(17'd11000, 17'd15000, 32'd1100, EvShort, 1'b1, 1'b0);
    add_sample(17'd11000, 17'd15000, 32'd2000);
    add_sample(17'd11000, 17'd15000, 32'd121100);
    add_checked(17'd11001, 17'h1FFFF, 32'd121200, EvNone, 1'b0, 1'b0);
    // An outage that straddles the wrap of the timestamp, then a timestamp
    // that steps backwards and so looks like a very long wait.
    add_sample(17'd3000, 17'd5000, 32'hFFFF_F000);
    add_sample(17'd3000, 17'd5000, 32'h0000_0BB8);
    add_sample(17'd0, 17'd5000, 32'h0000_0100);
    // Zero confirm time and zero cooldown: an alert on every sample.
    add_setting(RegShortConfirm, 32'd0);
    add_setting(RegShortCooldown, 32'd0);
    add_checked(17'd0, 17'h1FFFF, 32'd5, EvShort, 1'b1, 1'b0);
    add_checked(17'd0, 17'h1FFFF, 32'd5, EvShort, 1'b1, 1'b0);
    // With the outage limits wide open, a short still masks the outage.
    add_setting(RegOutVoltThr, LevelMax);
    add_setting(RegOutCurrMax, LevelMax);
    add_checked(17'd0, 17'h1FFFF, 32'd6, EvShort, 1'b1, 1'b0);
    add_sample(17'h1FFFF, 17'd0, 32'd7);
    // Short thresholds at their extremes make every sample a short.
    add_setting(RegShortCurrThr, 32'd0);
    add_setting(RegShortVoltCol, LevelMax);
    add_sample(17'h1FFFF, 17'd0, 32'd8);
    add_setting(RegOutConfirm, TimeMax);
    add_setting(RegOutCooldown, TimeMax);
    add_setting(RegShortConfirm, TimeMax);
    add_sample(17'h10000, 17'h10000, 32'd9);
    add_sample(17'h10000, 17'h10000, 32'd7);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_reg_write) begin
        settle_block();
        write_setting(row.reg_idx, row.reg_value);
      end else begin
        send_word(row.voltage, row.current, row.stamp, row.typed, row.typed_word);
      end
    end

    // Random part: each phase gets its own settings and pacing, cycling
    // through no idling, a mostly idle sender, a mostly stalling receiver and
    // both idling about a quarter of the time.
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      settle_block();
      for (int i = RegShortCurrThr; i <= RegOutCooldown; i++) begin
        write_setting(3'(i), pick_setting(3'(i), phase));
      end
      pace = phase % 4;
      sender_idle_pct = (pace == 1) ? 85 : ((pace == 3) ? 27 : 0);
      stall_pct       = (pace == 2) ? 85 : ((pace == 3) ? 27 : 0);
      run_phase(PhaseWords);
    end

    settle_block();
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d sample words under %0d register writes and four pacing modes;",
             words_sent, settings_written);
    $display("the block raised %0d short circuit and %0d outage alerts.",
             short_alerts, outage_alerts);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> fault_confirm_and_alert_limiter_core.f
sv/fcal_pkg.sv
sv/fcal_chan.sv
sv/fault_confirm_and_alert_limiter_core.sv
tb/sv/fault_confirm_and_alert_limiter_core_tb.sv
